// File: rtl/iidl_pkg.sv
// Package for the indexed insert/delete list.
// Holds the list depth, command and status codes, transaction types and the
// controller state and command/status structs. No dependencies.
package iidl_pkg;

  localparam int DEPTH    = 64;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int POS_W    = 7;
  localparam int COUNT_W  = 7;
  localparam int DATA_W   = 32;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_POS = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_PUT,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic ins_rd;
    logic ins_wr;
    logic ins_put;
    logic del_rd;
    logic del_wr;
    logic del_end;
    logic rd_rd;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic ins_ok;
    logic del_ok;
    logic rd_ok;
    logic ins_more;
    logic del_more;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/indexed_insert_delete_list.sv
// Indexed insert/delete list: top level joining controller and datapath.
// A rejected command goes straight to the result; a read reads its entry first; a
// delete shifts each later entry down, an insert shifts entries up and then puts its value.
// Each shift step is a read then a write on the entry memory.
// One command is in work at a time; a new one is taken only after the last finishes,
// later while a result waits for rsp_ready. Synchronous reset empties the list.
module indexed_insert_delete_list (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  iidl_pkg::req_t  req_data,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output iidl_pkg::rsp_t  rsp_data
);

  iidl_pkg::dp_cmd_t    dp_cmd;
  iidl_pkg::dp_status_t dp_status;

  iidl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  iidl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status)
  );

endmodule

// File: rtl/iidl_ctrl.sv
// Controller state machine for the indexed insert/delete list.
// Sequences the shift, put and read steps of each command. Uses iidl_pkg.
module iidl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  iidl_pkg::dp_status_t  dp_status,
  output iidl_pkg::dp_cmd_t     dp_cmd
);

  iidl_pkg::state_t state;
  iidl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iidl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      iidl_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (dp_status.ins_ok) begin
            state_next = iidl_pkg::ST_INS_RD;
          end else if (dp_status.del_ok) begin
            state_next = iidl_pkg::ST_DEL_RD;
          end else if (dp_status.rd_ok) begin
            state_next = iidl_pkg::ST_READ;
          end else begin
            state_next = iidl_pkg::ST_DONE;
          end
        end
      end
      iidl_pkg::ST_INS_RD: begin
        state_next = dp_status.ins_more ? iidl_pkg::ST_INS_WR : iidl_pkg::ST_INS_PUT;
      end
      iidl_pkg::ST_INS_WR:  state_next = iidl_pkg::ST_INS_RD;
      iidl_pkg::ST_INS_PUT: state_next = iidl_pkg::ST_DONE;
      iidl_pkg::ST_DEL_RD: begin
        state_next = dp_status.del_more ? iidl_pkg::ST_DEL_WR : iidl_pkg::ST_DONE;
      end
      iidl_pkg::ST_DEL_WR:  state_next = iidl_pkg::ST_DEL_RD;
      iidl_pkg::ST_READ:    state_next = iidl_pkg::ST_DONE;
      iidl_pkg::ST_DONE: begin
        if (dp_status.out_free) begin
          state_next = iidl_pkg::ST_IDLE;
        end
      end
      default: state_next = iidl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd    = '0;
    req_ready = 1'b0;
    unique case (state)
      iidl_pkg::ST_IDLE: begin
        req_ready   = 1'b1;
        dp_cmd.load = req_valid;
      end
      iidl_pkg::ST_INS_RD:  dp_cmd.ins_rd  = dp_status.ins_more;
      iidl_pkg::ST_INS_WR:  dp_cmd.ins_wr  = 1'b1;
      iidl_pkg::ST_INS_PUT: dp_cmd.ins_put = 1'b1;
      iidl_pkg::ST_DEL_RD: begin
        dp_cmd.del_rd  = dp_status.del_more;
        dp_cmd.del_end = !dp_status.del_more;
      end
      iidl_pkg::ST_DEL_WR:  dp_cmd.del_wr  = 1'b1;
      iidl_pkg::ST_READ:    dp_cmd.rd_rd   = 1'b1;
      iidl_pkg::ST_DONE:    dp_cmd.finish  = dp_status.out_free;
      default: dp_cmd = '0;
    endcase
  end

endmodule

// File: rtl/iidl_dp.sv
// Datapath for the indexed insert/delete list.
// Holds the entry memory, fill count, shift pointer and result register.
// Uses iidl_pkg.
module iidl_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  iidl_pkg::req_t        req_data,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output iidl_pkg::rsp_t        rsp_data,
  input  iidl_pkg::dp_cmd_t     dp_cmd,
  output iidl_pkg::dp_status_t  dp_status
);

  logic [iidl_pkg::DATA_W-1:0] mem [iidl_pkg::DEPTH];
  logic [iidl_pkg::DATA_W-1:0] rdata;

  logic [iidl_pkg::CNT_W-1:0]  count;
  logic [iidl_pkg::CNT_W-1:0]  ptr;
  logic [iidl_pkg::ADDR_W-1:0] pidx;
  logic [iidl_pkg::DATA_W-1:0] value;
  logic [1:0]                  status;
  logic                        is_read;

  logic [iidl_pkg::CMP_W-1:0]  pos_ext;
  logic [iidl_pkg::CMP_W-1:0]  cnt_ext;
  logic [iidl_pkg::CMP_W-1:0]  pos_m1;
  logic [iidl_pkg::CNT_W-1:0]  ptr_m1;
  logic                        ins_pos_ok;
  logic                        acc_pos_ok;
  logic                        full;
  logic                        wr_en;
  logic                        rd_en;
  logic [iidl_pkg::ADDR_W-1:0] waddr;
  logic [iidl_pkg::ADDR_W-1:0] raddr;
  logic [iidl_pkg::DATA_W-1:0] wdata;

  assign pos_ext    = iidl_pkg::CMP_W'(req_data.position);
  assign cnt_ext    = iidl_pkg::CMP_W'(count);
  assign pos_m1     = pos_ext - 1'b1;
  assign ptr_m1     = ptr - 1'b1;
  assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + 1'b1);
  assign acc_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign full       = count >= iidl_pkg::CNT_W'(iidl_pkg::DEPTH);

  assign dp_status.ins_ok   = (req_data.cmd == iidl_pkg::CMD_INSERT) && ins_pos_ok && !full;
  assign dp_status.del_ok   = (req_data.cmd == iidl_pkg::CMD_DELETE) && acc_pos_ok;
  assign dp_status.rd_ok    = (req_data.cmd == iidl_pkg::CMD_READ) && acc_pos_ok;
  assign dp_status.ins_more = ptr > iidl_pkg::CNT_W'(pidx);
  assign dp_status.del_more = ptr < count;
  assign dp_status.out_free = !rsp_valid || rsp_ready;

  assign wr_en = dp_cmd.ins_wr || dp_cmd.ins_put || dp_cmd.del_wr;
  assign rd_en = dp_cmd.ins_rd || dp_cmd.del_rd || dp_cmd.rd_rd;

  always_comb begin
    waddr = ptr[iidl_pkg::ADDR_W-1:0];
    wdata = rdata;
    if (dp_cmd.ins_put) begin
      waddr = pidx;
      wdata = value;
    end else if (dp_cmd.del_wr) begin
      waddr = ptr_m1[iidl_pkg::ADDR_W-1:0];
    end
  end

  always_comb begin
    raddr = ptr_m1[iidl_pkg::ADDR_W-1:0];
    if (dp_cmd.del_rd) begin
      raddr = ptr[iidl_pkg::ADDR_W-1:0];
    end else if (dp_cmd.rd_rd) begin
      raddr = pidx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      pidx    <= pos_m1[iidl_pkg::ADDR_W-1:0];
      value   <= req_data.value;
      is_read <= req_data.cmd == iidl_pkg::CMD_READ;
      if (req_data.cmd == iidl_pkg::CMD_INSERT) begin
        ptr <= count;
      end else begin
        ptr <= iidl_pkg::CNT_W'(pos_ext);
      end
      if (dp_status.ins_ok || dp_status.del_ok || dp_status.rd_ok) begin
        status <= iidl_pkg::STATUS_OK;
      end else if ((req_data.cmd == iidl_pkg::CMD_INSERT) && ins_pos_ok) begin
        status <= iidl_pkg::STATUS_FULL;
      end else begin
        status <= iidl_pkg::STATUS_BAD_POS;
      end
    end else if (dp_cmd.ins_wr) begin
      ptr <= ptr_m1;
    end else if (dp_cmd.del_wr) begin
      ptr <= ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (dp_cmd.ins_put) begin
      count <= count + 1'b1;
    end else if (dp_cmd.del_end) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (dp_cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.finish) begin
      rsp_data.status <= status;
      rsp_data.count  <= iidl_pkg::COUNT_W'(count);
      if (is_read && (status == iidl_pkg::STATUS_OK)) begin
        rsp_data.read_value <= rdata;
      end else begin
        rsp_data.read_value <= '0;
      end
    end
  end

endmodule
